/* rtl/core/mse_pkg.sv */
// ----------------------------------------------------------------------------
// mse_pkg
// Item types and fixed widths shared by the merge sort engine files.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int VALUE_W = 32;

    // one input item: an element of the set, last closes the set
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_item_t;

    // one result item: next sorted element
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      last_res;
        logic                      overflow;
    } out_item_t;

endpackage

/* rtl/core/mse_ram.sv */
// ----------------------------------------------------------------------------
// mse_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* rtl/core/merge_sort_engine.sv */
// ----------------------------------------------------------------------------
// merge_sort_engine
// Collects a set of signed values, sorts it with a stable merge sort and
// emits the values in ascending order.
// ----------------------------------------------------------------------------
// The block takes one item per cycle into its element store until an item
// with last set arrives; items beyond MAX_ELEMENTS are dropped and every
// result of that set then carries overflow. It then sorts the n held values
// bottom-up, ping-ponging each merge pass between two RAMs, and emits them
// ascending with last_res on the final one. While sorting or emitting it
// accepts no input. For a set of n values it makes ceil(log2 n) merge
// passes; each run pair first has its bounds set, and each merged element
// costs a RAM read and then a compare-and-write, since the RAM read
// latency sits in that loop. Each emitted item is read, loaded into the
// output register and then handed over once the sink takes it. A set of
// one value skips the sort.
// ----------------------------------------------------------------------------
module merge_sort_engine
    import mse_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // index bits for the store, count bits that also hold MAX_ELEMENTS
    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    // run bounds and the doubling run width grow past the count
    localparam int SUM_W  = CNT_W + 3;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RUN_SET,
        ST_MERGE_RD,
        ST_MERGE_WR,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;     // elements held
    logic             drop_reg, drop_next;   // element of this set dropped
    logic             sel_reg, sel_next;     // RAM holding the current runs
    logic [SUM_W-1:0] width_reg, width_next; // run width of this pass
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] i_reg, i_next;         // left run head
    logic [CNT_W-1:0] j_reg, j_next;         // right run head
    logic [CNT_W-1:0] k_reg, k_next;         // merge write position
    logic [CNT_W-1:0] e_reg, e_next;         // emit position
    out_item_t        out_reg, out_next;

    // RAM ports
    logic                    we0, we1;
    logic [ADDR_W-1:0]       waddr0, waddr1, raddr_a, raddr_b;
    logic [VALUE_W-1:0]      wdata0, wdata1;
    logic [VALUE_W-1:0]      rd0_a, rd0_b, rd1_a, rd1_b;

    // merge datapath
    logic [VALUE_W-1:0] head_a, head_b, merge_data;
    logic               take_left;
    logic               in_acc, has_room;
    logic [SUM_W-1:0]   n_ext, lo_w, lo_2w, width_dbl;
    logic [CNT_W-1:0]   k_inc, e_inc, cnt_inc;

    assign in_acc   = s_valid && s_ready;
    assign has_room = (cnt_reg < CNT_W'(MAX_ELEMENTS));
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign k_inc    = k_reg + CNT_W'(1);
    assign e_inc    = e_reg + CNT_W'(1);

    assign n_ext     = SUM_W'(cnt_reg);
    assign lo_w      = SUM_W'(lo_reg) + width_reg;
    assign lo_2w     = SUM_W'(lo_reg) + (width_reg << 1);
    assign width_dbl = width_reg << 1;

    // read data of the RAM that holds the source runs
    assign head_a = sel_reg ? rd1_a : rd0_a;
    assign head_b = sel_reg ? rd1_b : rd0_b;

    // left run wins on equal keys; an exhausted run never wins
    assign take_left  = (i_reg < mid_reg)
                        && ((j_reg >= hi_reg) || ($signed(head_a) <= $signed(head_b)));
    assign merge_data = take_left ? head_a : head_b;

    // RAM 0 takes incoming elements and the passes that write into it
    assign we0    = (in_acc && has_room) || ((state_reg == ST_MERGE_WR) && sel_reg);
    assign waddr0 = (state_reg == ST_LOAD) ? cnt_reg[ADDR_W-1:0] : k_reg[ADDR_W-1:0];
    assign wdata0 = (state_reg == ST_LOAD) ? s_data.value : merge_data;
    assign we1    = (state_reg == ST_MERGE_WR) && !sel_reg;
    assign waddr1 = k_reg[ADDR_W-1:0];
    assign wdata1 = merge_data;

    assign raddr_a = (state_reg == ST_EMIT_RD) ? e_reg[ADDR_W-1:0] : i_reg[ADDR_W-1:0];
    assign raddr_b = j_reg[ADDR_W-1:0];

    mse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .aclk    (aclk),
        .we      (we0),
        .waddr   (waddr0),
        .wdata   (wdata0),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    mse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_scratch (
        .aclk    (aclk),
        .we      (we1),
        .waddr   (waddr1),
        .wdata   (wdata1),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_EMIT_WAIT);
    assign m_data  = out_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        drop_next  = drop_reg;
        sel_next   = sel_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        e_next     = e_reg;
        out_next   = out_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    // store while there is room, otherwise drop and flag
                    if (has_room) begin
                        cnt_next = cnt_inc;
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_data.last) begin
                        sel_next   = 1'b0;
                        width_next = SUM_W'(1);
                        lo_next    = '0;
                        k_next     = '0;
                        e_next     = '0;
                        // a single value needs no sort
                        if (has_room && (cnt_reg == '0)) begin
                            state_next = ST_EMIT_RD;
                        end else begin
                            state_next = ST_RUN_SET;
                        end
                    end
                end
            end

            ST_RUN_SET: begin
                // bound the next run pair by the set size
                mid_next   = (lo_w < n_ext) ? lo_w[CNT_W-1:0] : cnt_reg;
                hi_next    = (lo_2w < n_ext) ? lo_2w[CNT_W-1:0] : cnt_reg;
                i_next     = lo_reg;
                j_next     = (lo_w < n_ext) ? lo_w[CNT_W-1:0] : cnt_reg;
                state_next = ST_MERGE_RD;
            end

            ST_MERGE_RD: begin
                // run heads are read this cycle
                state_next = ST_MERGE_WR;
            end

            ST_MERGE_WR: begin
                if (take_left) begin
                    i_next = i_reg + CNT_W'(1);
                end else begin
                    j_next = j_reg + CNT_W'(1);
                end
                k_next = k_inc;
                if (k_inc == hi_reg) begin
                    if (hi_reg == cnt_reg) begin
                        // pass done: flip source, double the run width
                        sel_next   = !sel_reg;
                        width_next = width_dbl;
                        lo_next    = '0;
                        k_next     = '0;
                        e_next     = '0;
                        if (width_dbl < n_ext) begin
                            state_next = ST_RUN_SET;
                        end else begin
                            state_next = ST_EMIT_RD;
                        end
                    end else begin
                        lo_next    = hi_reg;
                        state_next = ST_RUN_SET;
                    end
                end else begin
                    state_next = ST_MERGE_RD;
                end
            end

            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD: begin
                out_next.value_res = head_a;
                out_next.last_res  = (e_inc == cnt_reg);
                out_next.overflow  = drop_reg;
                state_next         = ST_EMIT_WAIT;
            end

            ST_EMIT_WAIT: begin
                if (m_ready) begin
                    if (out_reg.last_res) begin
                        // set delivered: empty the store
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end else begin
                        e_next     = e_inc;
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            sel_reg   <= sel_next;
        end
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        e_reg     <= e_next;
        out_reg   <= out_next;
    end

`ifndef ASSERT_OFF
    // input and output sides never open at once
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output both active");

    // the element count never passes capacity
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    // write position tracks both run heads during a merge
    a_merge_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE_RD || state_reg == ST_MERGE_WR)
        |-> (SUM_W'(k_reg) + SUM_W'(mid_reg) == SUM_W'(i_reg) + SUM_W'(j_reg)))
        else $error("merge write position out of step");

    // the final result hands the block back to loading
    a_last_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_res) |=> (s_ready && cnt_reg == '0))
        else $error("block not empty after final result");
`endif

endmodule

/* sim/merge_sort_engine_tb.sv */
// ----------------------------------------------------------------------------
// merge_sort_engine_tb
// Self-checking bench for the merge sort engine.
// ----------------------------------------------------------------------------
// Sends sets of signed values, closed by an item with last set, and predicts
// the sorted stream that each set must produce. The prediction covers
// overflow and last_res. Each result is checked field by field against the
// oldest predicted item. Both channels idle at random; some stretches run
// with no idling at all.
// ----------------------------------------------------------------------------
module merge_sort_engine_tb
    import mse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY   = 64;
    localparam int IDLE_LIMIT = 6000;   // cycles with no handshake on either side
    localparam int TAIL_WAIT  = 200;    // quiet cycles after the last result

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    merge_sort_engine #(
        .MAX_ELEMENTS(CAPACITY)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Predictor state: the values held for the open set.
    logic signed [VALUE_W-1:0] held_values [CAPACITY];
    int                        held_count;
    logic                      set_dropped;

    // Sorted items still owed by the block, oldest first.
    out_item_t sorted_expect [$];

    int  mismatches;
    int  idle_cycles;
    bit  no_idle;       // drop all random gaps on both sides while set

    // ------------------------------------------------------------------------
    // Clock: 8 ns period.
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor: absorb one accepted item; when it closes the set, sort the
    // held values (stable insertion sort) and queue the whole sorted stream.
    // ------------------------------------------------------------------------
    task automatic absorb_element(input in_item_t item);
        logic signed [VALUE_W-1:0] ordered [CAPACITY];
        logic signed [VALUE_W-1:0] key;
        out_item_t                 res;
        int                        i;
        int                        j;
        if (held_count < CAPACITY) begin
            held_values[held_count] = item.value;
            held_count++;
        end else begin
            set_dropped = 1'b1;     // store full: drop the element, flag the set
        end
        if (item.last) begin
            for (i = 0; i < held_count; i++) ordered[i] = held_values[i];
            // shift only strictly greater values so equal keys keep arrival order
            for (i = 1; i < held_count; i++) begin
                key = ordered[i];
                j   = i - 1;
                while (j >= 0 && ordered[j] > key) begin
                    ordered[j+1] = ordered[j];
                    j--;
                end
                ordered[j+1] = key;
            end
            for (i = 0; i < held_count; i++) begin
                res.value_res = ordered[i];
                res.last_res  = (i == held_count - 1);
                res.overflow  = set_dropped;
                sorted_expect.push_back(res);
            end
            held_count  = 0;
            set_dropped = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker and handshake watchdog counter. Sample at the rising
    // edge, before the block's registers update.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;

            if (m_valid && m_ready) begin
                if (sorted_expect.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got value %0d last %0b ovf %0b",
                             $time, m_data.value_res, m_data.last_res, m_data.overflow);
                    mismatches++;
                end else begin
                    want = sorted_expect.pop_front();
                    if (m_data.value_res !== want.value_res) begin
                        $display("%0t: value_res mismatch, expected %0d, got %0d",
                                 $time, want.value_res, m_data.value_res);
                        mismatches++;
                    end
                    if (m_data.last_res !== want.last_res) begin
                        $display("%0t: last_res mismatch, expected %0b, got %0b",
                                 $time, want.last_res, m_data.last_res);
                        mismatches++;
                    end
                    if (m_data.overflow !== want.overflow) begin
                        $display("%0t: overflow mismatch, expected %0b, got %0b",
                                 $time, want.overflow, m_data.overflow);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink: per result, hold m_ready low for a random gap, which may be empty,
    // then raise it and keep it up until an item is taken.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long.
    // ------------------------------------------------------------------------
    initial begin
        @(posedge aclk);
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Send one item: idle for a random gap, which may be empty, then hold
    // valid and payload until the block takes it. The caller continues in the
    // acceptance step, so a back-to-back item only rewrites the payload.
    task automatic send_item(input logic signed [VALUE_W-1:0] value, input logic last);
        in_item_t item;
        int       gap;
        item.value = value;
        item.last  = last;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        absorb_element(item);
    endtask

    // Drop valid and hold off until every predicted result has arrived.
    task automatic wait_all_sorted();
        s_valid <= 1'b0;
        while (sorted_expect.size() != 0) @(posedge aclk);
    endtask

    // Mix of wide random values, a narrow band that forces equal keys, and
    // the two extremes.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 8) - 4;
            1:       return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // A set of one value passes through the engine unchanged.
    task automatic test_single_value();
        send_item(VALUE_MIN, 1'b1);
        send_item(VALUE_MAX, 1'b1);
        wait_all_sorted();
    endtask

    // Extremes, zero, both signs and repeated keys in one set.
    task automatic test_extremes();
        send_item(VALUE_MAX, 1'b0);
        send_item(VALUE_MIN, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b0);
        send_item(VALUE_MIN, 1'b0);
        send_item(VALUE_MAX, 1'b0);
        send_item(0, 1'b1);
        wait_all_sorted();
    endtask

    // Already ascending, then fully descending input.
    task automatic test_ordered_input();
        int k;
        for (k = 0; k < 5; k++) send_item(k - 2, k == 4);
        for (k = 0; k < 5; k++) send_item(2 - k, k == 4);
        wait_all_sorted();
    endtask

    // Fill the store, then two more: one dropped plain, one dropped closing.
    task automatic test_overflow();
        int k;
        for (k = 0; k < CAPACITY + 2; k++) send_item(pick_value(), k == CAPACITY + 1);
        wait_all_sorted();
    endtask

    // Random sets, mostly small, now and then a mid-size one.
    task automatic test_random_sets(input int item_target);
        int sent;
        int set_size;
        int k;
        sent = 0;
        while (sent < item_target) begin
            set_size = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 32)
                                                   : $urandom_range(1, 8);
            for (k = 0; k < set_size; k++) send_item(pick_value(), k == set_size - 1);
            sent += set_size;
        end
        wait_all_sorted();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        held_count  = 0;
        set_dropped = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_value();
        test_extremes();
        test_ordered_input();
        test_overflow();
        test_random_sets(20);
        no_idle = 1'b1;         // a stretch with both sides at full rate
        test_random_sets(10);
        no_idle = 1'b0;

        // Catch any result emitted beyond the predicted stream.
        repeat (TAIL_WAIT) @(posedge aclk);

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
